// ===== design/mbrtu_pkg.sv =====
// Shared types and constants of the Modbus RTU slave frame handler.
`default_nettype none
package mbrtu_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SLAVE_ID      = 2'd0;
  localparam logic [1:0] REG_HOLDING_COUNT = 2'd1;
  localparam logic [1:0] REG_INPUT_COUNT   = 2'd2;

  // Function codes
  localparam logic [7:0] FN_READ_HOLD   = 8'd3;
  localparam logic [7:0] FN_READ_INPUT  = 8'd4;
  localparam logic [7:0] FN_WRITE_ONE   = 8'd6;
  localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

  // Exception codes and flag
  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;
  localparam logic [7:0] EXC_FLAG         = 8'h80;

  // Response kinds
  localparam logic [1:0] RSP_EXC  = 2'd0;
  localparam logic [1:0] RSP_READ = 2'd1;
  localparam logic [1:0] RSP_ECHO = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic clr_step;
    logic scan_init;
    logic scan_rd;
    logic scan_cap;
    logic crc_step;
    logic decide;
    logic wr_hi;
    logic wr_lo;
    logic wr_do;
    logic tx_fetch;
    logic tx_emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic early_drop;
    logic scan_crc;
    logic scan_done;
    logic bit_done;
    logic drop;
    logic multi;
    logic wr_last;
    logic tx_crc;
    logic tx_last;
  } sts_t;

  // One bit step of the reflected CRC16
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage
`default_nettype wire

// ===== design/mbrtu_ctrl.sv =====
// Controller state machine of the Modbus RTU slave frame handler.
`default_nettype none
module mbrtu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_accept,
  input  wire logic           in_action,
  input  wire logic           in_frame_end,
  input  wire mbrtu_pkg::sts_t sts,
  output mbrtu_pkg::cmd_t     cmd,
  output logic                busy
);
  import mbrtu_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CAP = 4'd4;
  localparam logic [3:0] S_SCAN_CRC = 4'd5;
  localparam logic [3:0] S_DECIDE   = 4'd6;
  localparam logic [3:0] S_WR_HI    = 4'd7;
  localparam logic [3:0] S_WR_LO    = 4'd8;
  localparam logic [3:0] S_WR_DO    = 4'd9;
  localparam logic [3:0] S_TX_FETCH = 4'd10;
  localparam logic [3:0] S_TX_EMIT  = 4'd11;
  localparam logic [3:0] S_TX_CRC   = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Decode next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && !in_action && in_frame_end) state_nxt = S_CHECK;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_CHECK: begin
        cmd.scan_init = 1'b1;
        state_nxt = sts.early_drop ? S_IDLE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = S_SCAN_CAP;
      end
      S_SCAN_CAP: begin
        cmd.scan_cap = 1'b1;
        priority if (sts.scan_crc) state_nxt = S_SCAN_CRC;
        else if (sts.scan_done)    state_nxt = S_DECIDE;
        else                       state_nxt = S_SCAN_RD;
      end
      S_SCAN_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.bit_done) state_nxt = sts.scan_done ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (sts.drop) state_nxt = S_IDLE;
        else if (sts.multi)    state_nxt = S_WR_HI;
        else                   state_nxt = S_TX_FETCH;
      end
      S_WR_HI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_WR_LO;
      end
      S_WR_LO: begin
        cmd.wr_lo = 1'b1;
        state_nxt = S_WR_DO;
      end
      S_WR_DO: begin
        cmd.wr_do = 1'b1;
        state_nxt = sts.wr_last ? S_TX_FETCH : S_WR_HI;
      end
      S_TX_FETCH: begin
        cmd.tx_fetch = 1'b1;
        state_nxt = S_TX_EMIT;
      end
      S_TX_EMIT: begin
        cmd.tx_emit = 1'b1;
        priority if (sts.tx_last) state_nxt = S_IDLE;
        else if (sts.tx_crc)      state_nxt = S_TX_CRC;
        else                      state_nxt = S_TX_FETCH;
      end
      S_TX_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.bit_done) state_nxt = S_TX_FETCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/mbrtu_dp.sv =====
// Datapath of the Modbus RTU slave: frame store, register files, CRC and response bytes.
`default_nettype none
module mbrtu_dp #(
  parameter int FRAME_MAX     = 64,
  parameter int HOLDING_DEPTH = 64,
  parameter int INPUT_DEPTH   = 64,
  parameter int MAX_READ      = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mbrtu_pkg::cmd_t cmd,
  output mbrtu_pkg::sts_t      sts,
  input  wire logic            in_accept,
  input  wire logic            in_action,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            in_frame_end,
  input  wire logic [5:0]      in_reg_index,
  input  wire logic [15:0]     in_reg_value,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_wdata,
  output logic                 out_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_tx_last
);
  import mbrtu_pkg::*;

  localparam int LW   = $clog2(FRAME_MAX + 1);
  localparam int FA   = $clog2(FRAME_MAX);
  localparam int HA   = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
  localparam int IA   = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int MAXD = (HOLDING_DEPTH > INPUT_DEPTH) ? HOLDING_DEPTH : INPUT_DEPTH;
  localparam int CA   = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int PW   = $clog2(2 * MAX_READ + 6);
  localparam int KW   = $clog2(HOLDING_DEPTH + 1);
  localparam int LIMW = ($clog2(MAXD + 1) > 7) ? $clog2(MAXD + 1) : 7;
  localparam int WAW  = (KW + 4 > FA) ? KW + 4 : FA;

  // Configuration registers
  logic [7:0] sid_r;
  logic [6:0] hc_r, ic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sid_r <= 8'd1;
      hc_r  <= 7'd64;
      ic_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLAVE_ID:      sid_r <= cfg_wdata;
        REG_HOLDING_COUNT: hc_r  <= cfg_wdata[6:0];
        REG_INPUT_COUNT:   ic_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Frame collection
  logic [LW-1:0] flen_r, n_r;
  logic          fovf_r, nbad_r;
  logic          room;
  logic [LW-1:0] len_inc;

  assign room    = flen_r < LW'(FRAME_MAX);
  assign len_inc = room ? flen_r + LW'(1) : flen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r <= '0;
      fovf_r <= 1'b0;
    end else if (in_accept && !in_action) begin
      if (in_frame_end) begin
        flen_r <= '0;
        fovf_r <= 1'b0;
      end else begin
        flen_r <= len_inc;
        fovf_r <= fovf_r | ~room;
      end
    end
  end

  // Latch the closed frame's length and early drop
  always_ff @(posedge clk) begin
    if (in_accept && !in_action && in_frame_end) begin
      n_r    <= len_inc;
      nbad_r <= fovf_r | ~room | (len_inc < LW'(4));
    end
  end

  // Scan, write-loop and response counters
  logic [LW-1:0] idx_r, pos_r, scan_end;
  logic [7:0]    hdr_r [0:6];
  logic [7:0]    rxlo_r, rxhi_r, hi_r;
  logic [15:0]   crc_r;
  logic [2:0]    bit_r;
  logic [1:0]    kind_r;
  logic [7:0]    code_r;
  logic [PW-1:0] txn_r, p_r;
  logic [KW-1:0] k_r;
  logic [CA-1:0] clr_r;
  logic [7:0]    frd_r;
  logic [15:0]   hrd_r, ird_r;

  assign scan_end = (n_r > LW'(7)) ? n_r : LW'(7);

  // Frame store
  logic [7:0]     fmem [0:FRAME_MAX-1];
  logic [FA-1:0]  faddr;
  logic [WAW-1:0] fa_w;

  always_comb begin
    fa_w = WAW'({k_r, 1'b0}) + (cmd.wr_lo ? WAW'(8) : WAW'(7));
    faddr = (cmd.wr_hi || cmd.wr_lo) ? fa_w[FA-1:0] : idx_r[FA-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_accept && !in_action && room) fmem[flen_r[FA-1:0]] <= in_rx_byte;
    frd_r <= fmem[faddr];
  end

  // Frame decoding
  logic [15:0] a, q;
  logic [16:0] aq, ak, rsum;
  logic [7:0]  func;
  logic [LIMW-1:0] lim_h, lim_i, lim_r;
  logic        is34, dec_drop, dec_one, dec_multi;
  logic [1:0]  dec_kind;
  logic [7:0]  dec_code;
  logic [PW-1:0] dec_txn;
  logic [16:0] rtx;
  logic [PW-1:0] pm3;

  always_comb begin
    a     = {hdr_r[2], hdr_r[3]};
    q     = {hdr_r[4], hdr_r[5]};
    func  = hdr_r[1];
    aq    = {1'b0, a} + {1'b0, q};
    lim_h = (LIMW'(hc_r) < LIMW'(HOLDING_DEPTH)) ? LIMW'(hc_r) : LIMW'(HOLDING_DEPTH);
    lim_i = (LIMW'(ic_r) < LIMW'(INPUT_DEPTH)) ? LIMW'(ic_r) : LIMW'(INPUT_DEPTH);
    lim_r = (func == FN_READ_HOLD) ? lim_h : lim_i;
    is34  = (func == FN_READ_HOLD) || (func == FN_READ_INPUT);
    rtx   = {q, 1'b0} + 17'd3;
    dec_drop  = (hdr_r[0] != sid_r) || (crc_r != {rxhi_r, rxlo_r}) ||
                ((is34 || func == FN_WRITE_ONE) && n_r != LW'(8));
    dec_one   = 1'b0;
    dec_multi = 1'b0;
    dec_kind  = RSP_EXC;
    dec_code  = EXC_ILLEGAL_FUNC;
    dec_txn   = PW'(3);
    if (is34) begin
      if (q == 16'd0 || q > 16'(MAX_READ) || aq > 17'(lim_r)) begin
        dec_code = EXC_ILLEGAL_ADDR;
      end else begin
        dec_kind = RSP_READ;
        dec_txn  = rtx[PW-1:0];
      end
    end else if (func == FN_WRITE_ONE) begin
      if ({1'b0, a} < 17'(lim_h)) begin
        dec_one  = 1'b1;
        dec_kind = RSP_ECHO;
        dec_txn  = PW'(6);
      end
    end else if (func == FN_WRITE_MULTI) begin
      if ({q, 1'b0} == 17'(hdr_r[6]) && aq <= 17'(lim_h) &&
          18'(n_r) == ({1'b0, q, 1'b0} + 18'd9)) begin
        dec_multi = (q != 16'd0);
        dec_kind  = RSP_ECHO;
        dec_txn   = PW'(6);
      end
    end
    ak   = {1'b0, a} + 17'(k_r);
    pm3  = p_r - PW'(3);
    rsum = {1'b0, a} + 17'(pm3 >> 1);
  end

  // Sequence the scan, the CRC and the response
  logic [7:0] tx_b;

  always_comb begin
    priority if (p_r == txn_r)              tx_b = crc_r[7:0];
    else if (p_r == PW'(txn_r + PW'(1)))    tx_b = crc_r[15:8];
    else if (p_r == PW'(0))                 tx_b = sid_r;
    else if (p_r == PW'(1))                 tx_b = (kind_r == RSP_EXC) ? (func | EXC_FLAG) : func;
    else if (kind_r == RSP_EXC)             tx_b = code_r;
    else if (kind_r == RSP_READ) begin
      if (p_r == PW'(2))      tx_b = {hdr_r[5][6:0], 1'b0};
      else if (func == FN_READ_HOLD) tx_b = p_r[0] ? hrd_r[15:8] : hrd_r[7:0];
      else                    tx_b = p_r[0] ? ird_r[15:8] : ird_r[7:0];
    end else begin
      unique case (p_r)
        PW'(2):  tx_b = hdr_r[2];
        PW'(3):  tx_b = hdr_r[3];
        PW'(4):  tx_b = hdr_r[4];
        default: tx_b = hdr_r[5];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx_r <= '0;
      crc_r <= CRC_INIT;
    end
    if (cmd.scan_rd) begin
      pos_r <= idx_r;
      idx_r <= idx_r + LW'(1);
    end
    if (cmd.scan_cap) begin
      if (pos_r < LW'(7)) hdr_r[pos_r[2:0]] <= frd_r;
      if (pos_r == n_r - LW'(2)) rxlo_r <= frd_r;
      if (pos_r == n_r - LW'(1)) rxhi_r <= frd_r;
      if (sts.scan_crc) crc_r <= crc_r ^ {8'h00, frd_r};
      bit_r <= '0;
    end
    if (cmd.crc_step) begin
      crc_r <= crc_bit(crc_r);
      bit_r <= bit_r + 3'd1;
    end
    if (cmd.decide) begin
      kind_r <= dec_kind;
      code_r <= dec_code;
      txn_r  <= dec_txn;
      p_r    <= '0;
      k_r    <= '0;
      crc_r  <= CRC_INIT;
    end
    if (cmd.wr_lo) hi_r <= frd_r;
    if (cmd.wr_do) k_r <= k_r + KW'(1);
    if (cmd.tx_emit) begin
      if (sts.tx_crc) crc_r <= crc_r ^ {8'h00, tx_b};
      bit_r <= '0;
      p_r   <= p_r + PW'(1);
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + CA'(1);
    end
  end

  // Holding register file
  logic [15:0]   hmem [0:HOLDING_DEPTH-1];
  logic          hwe;
  logic [HA-1:0] hwa;
  logic [15:0]   hwd;

  always_comb begin
    hwe = 1'b0;
    hwa = ak[HA-1:0];
    hwd = {hi_r, frd_r};
    if (cmd.clr_step) begin
      hwe = int'(clr_r) < HOLDING_DEPTH;
      hwa = HA'(clr_r);
      hwd = '0;
    end else if (cmd.decide) begin
      hwe = dec_one && !dec_drop;
      hwa = a[HA-1:0];
      hwd = q;
    end else if (cmd.wr_do) begin
      hwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hwe) hmem[hwa] <= hwd;
    if (cmd.tx_fetch) hrd_r <= hmem[rsum[HA-1:0]];
  end

  // Input register file
  logic [15:0]   imem [0:INPUT_DEPTH-1];
  logic          iwe;
  logic [IA-1:0] iwa;
  logic [15:0]   iwd;

  always_comb begin
    if (cmd.clr_step) begin
      iwe = int'(clr_r) < INPUT_DEPTH;
      iwa = IA'(clr_r);
      iwd = '0;
    end else begin
      iwe = in_accept && in_action && (int'(in_reg_index) < INPUT_DEPTH);
      iwa = IA'(in_reg_index);
      iwd = in_reg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (iwe) imem[iwa] <= iwd;
    if (cmd.tx_fetch) ird_r <= imem[rsum[IA-1:0]];
  end

  // Result strobe and byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.tx_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tx_emit) begin
      out_tx_byte <= tx_b;
      out_tx_last <= sts.tx_last;
    end
  end

  // Status to the controller
  always_comb begin
    sts.clr_done   = (int'(clr_r) == MAXD - 1);
    sts.early_drop = nbad_r;
    sts.scan_crc   = cmd.scan_cap && (({1'b0, pos_r} + (LW + 1)'(2)) < {1'b0, n_r});
    sts.scan_done  = (idx_r == scan_end);
    sts.bit_done   = (bit_r == 3'd7);
    sts.drop       = dec_drop;
    sts.multi      = dec_multi;
    sts.wr_last    = ((17'(k_r) + 17'd1) == {1'b0, q});
    sts.tx_crc     = (p_r < txn_r);
    sts.tx_last    = (p_r == PW'(txn_r + PW'(1)));
  end

endmodule
`default_nettype wire

// ===== design/modbus_rtu_slave_frame_handler.sv =====
// Top level of the Modbus RTU slave frame handler.
//
// Requests enter on start when busy is low: action 0 carries one received byte
// (frame_end marks the last byte of a frame), action 1 loads an input register.
// A byte that does not close a frame and a register load leave busy low, and
// the next request may follow in the next cycle.
// At frame end the frame store is walked over max(n,7) bytes of an n-byte frame,
// each byte read and then captured, and the bit-serial CRC unit shifts eight
// bits for each covered byte. A write-multiple request then writes each register
// as high byte, low byte, then the write. Each response byte is fetched and
// emitted, with eight CRC bit steps for each byte before the two CRC bytes; the
// scan and the response share one CRC unit; the block works on one frame at a time.
// Responses leave on out_tx_byte with out_valid high for one cycle each,
// out_tx_last on the final byte. The receiver cannot stall the block.
// After reset the register files are cleared, one entry a cycle, with busy
// high; configuration writes on cfg_we are taken at any time.
`default_nettype none
module modbus_rtu_slave_frame_handler #(
  parameter int FRAME_MAX     = 64,
  parameter int HOLDING_DEPTH = 64,
  parameter int INPUT_DEPTH   = 64,
  parameter int MAX_READ      = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_end,
  input  wire logic [5:0]  in_reg_index,
  input  wire logic [15:0] in_reg_value,
  output logic             out_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import mbrtu_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign in_accept = start && !busy;

  mbrtu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_action    (in_action),
    .in_frame_end (in_frame_end),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  mbrtu_dp #(
    .FRAME_MAX     (FRAME_MAX),
    .HOLDING_DEPTH (HOLDING_DEPTH),
    .INPUT_DEPTH   (INPUT_DEPTH),
    .MAX_READ      (MAX_READ)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_accept    (in_accept),
    .in_action    (in_action),
    .in_rx_byte   (in_rx_byte),
    .in_frame_end (in_frame_end),
    .in_reg_index (in_reg_index),
    .in_reg_value (in_reg_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_tx_byte  (out_tx_byte),
    .out_tx_last  (out_tx_last)
  );

endmodule
`default_nettype wire
